// ----- hw/rtl/bms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_pkg
// Shared widths, codes and types of the bilinear height map sampler.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int unsigned MAX_WIDTH  = 256;
	localparam int unsigned MAX_HEIGHT = 256;
	localparam int unsigned TEXEL_BITS = 16;
	localparam int unsigned FRAC_BITS  = 16;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned SIZE_W  = 9;
	localparam int unsigned COORD_W = FRAC_BITS + 1;
	localparam int unsigned VAL_W   = 16;

	localparam int unsigned BANKS      = 4;
	localparam int unsigned BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / BANKS;
	localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

	localparam int unsigned PU_W    = COORD_W + POS_W;
	localparam int unsigned WGT_W   = FRAC_BITS + 1;
	localparam int unsigned PROD_W  = TEXEL_BITS + FRAC_BITS;
	localparam int unsigned BLEND_W = TEXEL_BITS + 2 * FRAC_BITS;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_POINT  = 2'd1,
		CMD_SAMPLE = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0] sample_value;
		logic             out_of_range;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bms_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_in_if
// Command channel: texel writes, point reads and bilinear samples.
// ----------------------------------------------------------------------------
interface bms_in_if import bms_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic [VAL_W-1:0]   texel_value;
	logic [COORD_W-1:0] coord_u;
	logic [COORD_W-1:0] coord_v;

	modport source (
		output valid, cmd, pos_x, pos_y, texel_value, coord_u, coord_v,
		input  ready
	);

	modport sink (
		input  valid, cmd, pos_x, pos_y, texel_value, coord_u, coord_v,
		output ready
	);

endinterface
`default_nettype wire

// ----- hw/rtl/bms_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_out_if
// Result channel: point texel or blended value with range flag.
// ----------------------------------------------------------------------------
interface bms_out_if import bms_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] sample_value;
	logic             out_of_range;

	modport source (
		output valid, sample_value, out_of_range,
		input  ready
	);

	modport sink (
		input  valid, sample_value, out_of_range,
		output ready
	);

endinterface
`default_nettype wire

// ----- hw/rtl/bms_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_ram
// Single-port synchronous RAM, registered read, write has priority.
// ----------------------------------------------------------------------------
module bms_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16384,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bilinear_map_sampler_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_map_sampler_top
// Height map in four parity banks; point reads and bilinear samples.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------
//  item     | in  | valid/ready         | cmd, pos_x, pos_y, texel_value,
//           |     |                     | coord_u, coord_v
//  result   | out | valid/ready         | sample_value, out_of_range
//  apb      | in  | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
//  One item per cycle while item ready is high. A read result passes these
//  registered steps before it enters the 8-entry result FIFO: scale multiply,
//  bank read, four texel products, row sums, column products, final sum.
//  The four banks (even/odd column x even/odd row) give all four neighbors
//  in a single read. Item ready drops when 8 results are in flight or
//  queued. The map has no reset; registers reset to 256.
// ----------------------------------------------------------------------------
module bilinear_map_sampler_top import bms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	bms_in_if.sink            item,
	bms_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
			input logic [SIZE_W-1:0] maxv);
		if (r == '0) begin
			return SIZE_W'(1);
		end else if (r > maxv) begin
			return maxv;
		end else begin
			return r;
		end
	endfunction

	// configuration
	logic [SIZE_W-1:0] map_width_q, map_height_q;
	logic              cfg_we;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= SIZE_W'(MAX_WIDTH);
			map_height_q <= SIZE_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAP_WIDTH:  map_width_q  <= pwdata[SIZE_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MAP_WIDTH:  prdata = APB_DW'(map_width_q);
			REG_MAP_HEIGHT: prdata = APB_DW'(map_height_q);
			default:        prdata = '0;
		endcase
	end

	logic [SIZE_W-1:0] w_eff, h_eff;
	logic [POS_W-1:0]  w_m1, h_m1;

	assign w_eff = eff_size(map_width_q, SIZE_W'(MAX_WIDTH));
	assign h_eff = eff_size(map_height_q, SIZE_W'(MAX_HEIGHT));
	assign w_m1  = POS_W'(w_eff - SIZE_W'(1));
	assign h_m1  = POS_W'(h_eff - SIZE_W'(1));

	// input transfer and result credits
	logic               in_xfer, out_xfer, in_rd;
	logic [FIFO_CW-1:0] credit_q;

	assign item.ready = (credit_q != FIFO_CW'(FIFO_DEPTH));
	assign in_xfer    = item.valid & item.ready;
	assign in_rd      = (item.cmd == CMD_POINT) || (item.cmd == CMD_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if ((in_xfer && in_rd) && !out_xfer) begin
			credit_q <= credit_q + FIFO_CW'(1);
		end else if (!(in_xfer && in_rd) && out_xfer) begin
			credit_q <= credit_q - FIFO_CW'(1);
		end
	end

	// stage 1: coordinate scaling
	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [POS_W-1:0]   px_s1, py_s1;
	logic [VAL_W-1:0]   tv_s1;
	logic [PU_W-1:0]    pu_s1, pv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= item.cmd;
		px_s1  <= item.pos_x;
		py_s1  <= item.pos_y;
		tv_s1  <= item.texel_value;
		pu_s1  <= PU_W'(item.coord_u) * PU_W'(w_m1);
		pv_s1  <= PU_W'(item.coord_v) * PU_W'(h_m1);
	end

	// stage 1 -> bank access
	logic [SIZE_W-1:0]    u0, v0;
	logic [SIZE_W:0]      u0_inc, v0_inc;
	logic [POS_W-1:0]     u1, v1, col0, col1, row0, row1;
	logic [FRAC_BITS-1:0] fu_sel, fv_sel;
	logic                 is_wr, is_smp, is_rd, oob;
	logic [POS_W-1:0]     bank_col  [BANKS];
	logic [POS_W-1:0]     bank_row  [BANKS];
	logic [BANK_AW-1:0]   bank_addr [BANKS];
	logic [BANKS-1:0]     bank_en;
	logic [VAL_W-1:0]     bank_rdata [BANKS];

	always_comb begin
		u0     = pu_s1[PU_W-1:FRAC_BITS];
		v0     = pv_s1[PU_W-1:FRAC_BITS];
		u0_inc = {1'b0, u0} + (SIZE_W+1)'(1);
		v0_inc = {1'b0, v0} + (SIZE_W+1)'(1);
		u1     = (u0_inc < {1'b0, w_eff}) ? u0_inc[POS_W-1:0] : w_m1;
		v1     = (v0_inc < {1'b0, h_eff}) ? v0_inc[POS_W-1:0] : h_m1;
		is_wr  = (cmd_s1 == CMD_WRITE);
		is_smp = (cmd_s1 == CMD_SAMPLE);
		is_rd  = (cmd_s1 == CMD_POINT) || is_smp;
		if (is_smp) begin
			col0   = u0[POS_W-1:0];
			col1   = u1;
			row0   = v0[POS_W-1:0];
			row1   = v1;
			fu_sel = pu_s1[FRAC_BITS-1:0];
			fv_sel = pv_s1[FRAC_BITS-1:0];
			oob    = (u0 >= w_eff) || (v0 >= h_eff);
		end else begin
			col0   = px_s1;
			col1   = px_s1;
			row0   = py_s1;
			row1   = py_s1;
			fu_sel = '0;
			fv_sel = '0;
			oob    = ({1'b0, px_s1} >= w_eff) || ({1'b0, py_s1} >= h_eff);
		end
		for (int b = 0; b < BANKS; b++) begin
			if (is_wr) begin
				bank_col[b] = px_s1;
				bank_row[b] = py_s1;
			end else begin
				bank_col[b] = (col0[0] == 1'(b)) ? col0 : col1;
				bank_row[b] = (row0[0] == 1'(b >> 1)) ? row0 : row1;
			end
			bank_addr[b] = {bank_row[b][POS_W-1:1], bank_col[b][POS_W-1:1]};
			bank_en[b]   = valid_s1 && (is_rd || (is_wr && px_s1[0] == 1'(b)
				&& py_s1[0] == 1'(b >> 1)));
		end
	end

	for (genvar g = 0; g < BANKS; g++) begin : g_bank
		bms_ram #(
			.WIDTH(TEXEL_BITS),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.en   (bank_en[g]),
			.we   (is_wr),
			.addr (bank_addr[g]),
			.wdata(tv_s1),
			.rdata(bank_rdata[g])
		);
	end

	// stage 2: texel products
	logic                 valid_s2, oob_s2, c0p_s2, c1p_s2, r0p_s2, r1p_s2;
	logic [FRAC_BITS-1:0] fu_s2, fv_s2;
	logic [VAL_W-1:0]     t00, t10, t01, t11;
	logic [WGT_W-1:0]     wu0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && is_rd;
		end
	end

	always_ff @(posedge clk) begin
		oob_s2 <= oob;
		fu_s2  <= fu_sel;
		fv_s2  <= fv_sel;
		c0p_s2 <= col0[0];
		c1p_s2 <= col1[0];
		r0p_s2 <= row0[0];
		r1p_s2 <= row1[0];
	end

	assign t00 = bank_rdata[{r0p_s2, c0p_s2}];
	assign t10 = bank_rdata[{r0p_s2, c1p_s2}];
	assign t01 = bank_rdata[{r1p_s2, c0p_s2}];
	assign t11 = bank_rdata[{r1p_s2, c1p_s2}];
	assign wu0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fu_s2};

	logic                 valid_s3, oob_s3;
	logic [FRAC_BITS-1:0] fv_s3;
	logic [PROD_W-1:0]    p00_s3, p10_s3, p01_s3, p11_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		oob_s3 <= oob_s2;
		fv_s3  <= fv_s2;
		p00_s3 <= PROD_W'(t00 * wu0);
		p10_s3 <= PROD_W'(t10 * fu_s2);
		p01_s3 <= PROD_W'(t01 * wu0);
		p11_s3 <= PROD_W'(t11 * fu_s2);
	end

	// stage 3: row sums
	logic                 valid_s4, oob_s4;
	logic [FRAC_BITS-1:0] fv_s4;
	logic [PROD_W-1:0]    r0_s4, r1_s4;
	logic [WGT_W-1:0]     wv0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		oob_s4 <= oob_s3;
		fv_s4  <= fv_s3;
		r0_s4  <= p00_s3 + p10_s3;
		r1_s4  <= p01_s3 + p11_s3;
	end

	assign wv0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fv_s4};

	// stage 4: column products
	logic               valid_s5, oob_s5;
	logic [BLEND_W-1:0] q0_s5, q1_s5, blend_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		oob_s5 <= oob_s4;
		q0_s5  <= BLEND_W'(r0_s4 * wv0);
		q1_s5  <= BLEND_W'(r1_s4 * fv_s4);
	end

	// stage 5: final sum into result FIFO
	result_t push_data;

	always_comb begin
		blend_sum = q0_s5 + q1_s5;
		if (oob_s5) begin
			push_data.sample_value = '0;
			push_data.out_of_range = 1'b1;
		end else begin
			push_data.sample_value = blend_sum[BLEND_W-1 -: VAL_W];
			push_data.out_of_range = 1'b0;
		end
	end

	result_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] fill_q;

	assign result.valid        = (fill_q != '0);
	assign result.sample_value = fifo_q[rd_ptr_q].sample_value;
	assign result.out_of_range = fifo_q[rd_ptr_q].out_of_range;
	assign out_xfer            = result.valid & result.ready;

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (valid_s5) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
			end
			if (valid_s5 && !out_xfer) begin
				fill_q <= fill_q + FIFO_CW'(1);
			end else if (!valid_s5 && out_xfer) begin
				fill_q <= fill_q - FIFO_CW'(1);
			end
		end
	end

endmodule
`default_nettype wire
